### rtl/mpam_pkg.sv
// Shared types and codes for the multi-pattern automaton matcher.
package mpam_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_END     = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_SCAN    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_REJECT = 2'd2,
        STS_RSVD   = 2'd3
    } t_status;

    localparam int unsigned SYM_W   = 8;
    localparam int unsigned NODE_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

### rtl/mpam_if.sv
// Input and result stream interfaces of the automaton matcher.
interface mpam_in_if;
    import mpam_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [SYM_W-1:0]  symbol;
    modport source (output valid, action, symbol, input ready);
    modport sink   (input valid, action, symbol, output ready);
endinterface

interface mpam_out_if;
    import mpam_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [NODE_W-1:0]  node;
    logic               match_found;
    logic [NODE_W-1:0]  match_node;
    logic [COUNT_W-1:0] word_count;
    modport source (output valid, status, node, match_found, match_node, word_count,
                    input ready);
    modport sink   (input valid, status, node, match_found, match_node, word_count,
                    output ready);
endinterface

### rtl/mpam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpam_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/multi_pattern_automaton_matcher.sv
// Aho-Corasick dictionary matcher: trie build, one-time link pass, symbol scan.
//
//  channel | dir | fields                                         | beat when
//  i_in    | in  | action, symbol                                 | valid & ready
//  o_out   | out | status, node, match_found, match_node, word_count | valid & ready
//
// Reset: synchronous, active low; afterwards a clearing pass over
// all MAX_NODES*ALPHABET_SIZE entries sweeps the child table (and word counts), no beat taken.
// Insert and end word read the child or word table before the result; restart responds at once.
// Scan follows suffix links to a child, reads the exit table, then the word count on a match.
// First scan also runs the link pass over each (node, symbol) pair of the queued nodes,
// plus the suffix walks; its pace is set by the single read port of each table RAM.
// One item at a time; the result register lets the next beat in while a result waits,
// and the sequencer stalls in its final cycle while that register is still held.
module multi_pattern_automaton_matcher
    import mpam_pkg::*;
#(
    parameter int unsigned MAX_NODES     = 256,
    parameter int unsigned ALPHABET_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpam_in_if.sink     i_in,
    mpam_out_if.source  o_out
);
    localparam int unsigned NB = $clog2(MAX_NODES);
    localparam int unsigned SB = $clog2(ALPHABET_SIZE);
    localparam int unsigned AW = $clog2(MAX_NODES * ALPHABET_SIZE);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_NODES * ALPHABET_SIZE - 1);
    localparam logic [AW-1:0] CLR_WORDS = AW'(MAX_NODES);
    localparam logic [NB:0]   NODES_END = (NB+1)'(MAX_NODES);
    localparam logic [SB-1:0] SYM_LAST = SB'(ALPHABET_SIZE - 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_INS_RD, ST_INS_EV, ST_END_RD, ST_END_EV,
        ST_CNT_RD, ST_CNT_EV, ST_F_W0, ST_F_INIT, ST_F_POP, ST_F_POPW,
        ST_F_CH, ST_F_CHW, ST_F_LINK, ST_F_LINKW, ST_G_RD, ST_G_EV,
        ST_S_EXT, ST_S_EXTW, ST_RESP
    } t_state;

    // fold a raw symbol into the alphabet by restoring subtraction
    function automatic logic [SB-1:0] f_mod(input logic [SYM_W-1:0] x);
        logic [15:0] r;
        r = 16'(x);
        for (int k = 7; k >= 0; k--) begin
            if (r >= (16'(ALPHABET_SIZE) << k)) begin
                r = r - (16'(ALPHABET_SIZE) << k);
            end
        end
        return SB'(r);
    endfunction

    t_state r_state;
    logic [AW-1:0]      r_clr;
    logic [SB-1:0]      r_sym, r_s;
    logic [NB-1:0]      r_build, r_scan, r_v, r_y, r_ch, r_lk, r_wa;
    logic [NB:0]        r_used, r_head, r_tail;
    logic               r_begun, r_in_frz;
    t_status            r_res_status;
    logic [NODE_W-1:0]  r_res_node, r_res_mnode;
    logic               r_res_found;
    logic [COUNT_W-1:0] r_res_count;
    logic               r_ov;
    t_status            r_o_status;
    logic [NODE_W-1:0]  r_o_node, r_o_mnode;
    logic               r_o_found;
    logic [COUNT_W-1:0] r_o_count;

    // RAM ports
    logic          ch_we;   logic [AW-1:0] ch_addr; logic [NB:0] ch_wd, ch_q;
    logic          wd_we;   logic [NB-1:0] wd_wa, wd_ra; logic [COUNT_W-1:0] wd_wd, wd_q;
    logic          sf_we;   logic [NB-1:0] sf_wa, sf_ra, sf_wd, sf_q;
    logic          ex_we;   logic [NB-1:0] ex_wa, ex_ra; logic [NB:0] ex_wd, ex_q;
    logic          qu_we;   logic [NB-1:0] qu_wa, qu_ra, qu_wd, qu_q;
    logic [NB-1:0] a_v;     logic [SB-1:0] a_s;
    logic [SB-1:0] walk_s;
    logic [COUNT_W-1:0] sat_inc;

    assign walk_s  = r_in_frz ? r_s : r_sym;
    assign sat_inc = (wd_q == COUNT_MAX) ? wd_q : wd_q + 1'b1;
    assign ch_addr = (r_state == ST_CLEAR) ? r_clr
                   : AW'(a_v) * AW'(ALPHABET_SIZE) + AW'(a_s);

    // drive table addresses and writes from the sequencer state
    always_comb begin
        a_v = r_build; a_s = r_sym;
        ch_we = 1'b0; ch_wd = {1'b1, NB'(0)};
        wd_we = 1'b0; wd_wa = r_build; wd_wd = '0; wd_ra = r_wa;
        sf_we = 1'b0; sf_wa = r_ch; sf_wd = r_lk; sf_ra = r_y;
        ex_we = 1'b0; ex_wa = r_ch; ex_wd = ex_q; ex_ra = r_lk;
        qu_we = 1'b0; qu_wa = r_tail[NB-1:0]; qu_wd = r_ch; qu_ra = r_head[NB-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                ch_we = 1'b1;
                wd_we = (r_clr < CLR_WORDS);
                wd_wa = r_clr[NB-1:0];
            end
            ST_INS_EV: begin
                ch_we = ch_q[NB] && (r_used < NODES_END);
                ch_wd = {1'b0, r_used[NB-1:0]};
            end
            ST_END_RD: wd_ra = r_build;
            ST_END_EV: begin
                wd_we = 1'b1;
                wd_wd = sat_inc;
            end
            ST_F_W0: wd_ra = '0;
            ST_F_INIT: begin
                sf_we = 1'b1; sf_wa = '0; sf_wd = '0;
                ex_we = 1'b1; ex_wa = '0;
                ex_wd = (wd_q != '0) ? {1'b0, NB'(0)} : {1'b1, NB'(0)};
                qu_we = 1'b1; qu_wa = '0; qu_wd = '0;
            end
            ST_F_CH: begin
                a_v = r_v; a_s = r_s; sf_ra = r_v;
            end
            ST_F_LINK: begin
                sf_we = 1'b1; wd_ra = r_ch;
            end
            ST_F_LINKW: begin
                ex_we = 1'b1;
                ex_wd = (wd_q != '0) ? {1'b0, r_ch} : ex_q;
                qu_we = (r_tail < NODES_END);
            end
            ST_G_RD: begin
                a_v = r_y; a_s = walk_s; sf_ra = r_y;
            end
            ST_S_EXT: ex_ra = r_scan;
            default: ;
        endcase
    end

    // sequencer, datapath registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_used  <= (NB+1)'(1);
            r_build <= '0;
            r_scan  <= '0;
            r_begun <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded
            if (r_ov && o_out.ready && r_state != ST_RESP) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_sym        <= f_mod(i_in.symbol);
                        r_res_status <= STS_OK;
                        r_res_node   <= '0;
                        r_res_found  <= 1'b0;
                        r_res_mnode  <= '0;
                        r_res_count  <= '0;
                        r_wa         <= r_build;
                        unique case (t_action'(i_in.action))
                            ACT_INSERT, ACT_END: begin
                                if (r_begun) begin
                                    r_res_status <= STS_REJECT;
                                    r_res_node   <= NODE_W'(r_build);
                                    r_state      <= ST_CNT_RD;
                                end else if (t_action'(i_in.action) == ACT_INSERT) begin
                                    r_state <= ST_INS_RD;
                                end else begin
                                    r_state <= ST_END_RD;
                                end
                            end
                            ACT_RESTART: begin
                                r_scan  <= '0;
                                r_state <= ST_RESP;
                            end
                            ACT_SCAN: begin
                                r_in_frz <= 1'b0;
                                r_y      <= r_scan;
                                if (!r_begun) begin
                                    r_begun <= 1'b1;
                                    r_state <= ST_F_W0;
                                end else begin
                                    r_state <= ST_G_RD;
                                end
                            end
                            default: r_state <= ST_RESP;
                        endcase
                    end
                end
                ST_INS_RD: r_state <= ST_INS_EV;
                ST_INS_EV: begin
                    if (!ch_q[NB]) begin
                        r_build    <= ch_q[NB-1:0];
                        r_wa       <= ch_q[NB-1:0];
                        r_res_node <= NODE_W'(ch_q[NB-1:0]);
                        r_state    <= ST_CNT_RD;
                    end else if (r_used >= NODES_END) begin
                        r_res_status <= STS_FULL;
                        r_res_node   <= NODE_W'(r_build);
                        r_state      <= ST_CNT_RD;
                    end else begin
                        r_build    <= r_used[NB-1:0];
                        r_used     <= r_used + 1'b1;
                        r_res_node <= NODE_W'(r_used[NB-1:0]);
                        r_state    <= ST_RESP;
                    end
                end
                ST_END_RD: r_state <= ST_END_EV;
                ST_END_EV: begin
                    r_res_node  <= NODE_W'(r_build);
                    r_res_count <= sat_inc;
                    r_build     <= '0;
                    r_state     <= ST_RESP;
                end
                ST_CNT_RD: r_state <= ST_CNT_EV;
                ST_CNT_EV: begin
                    r_res_count <= wd_q;
                    r_state     <= ST_RESP;
                end
                // link pass in breadth-first order
                ST_F_W0: r_state <= ST_F_INIT;
                ST_F_INIT: begin
                    r_head  <= '0;
                    r_tail  <= (NB+1)'(1);
                    r_state <= ST_F_POP;
                end
                ST_F_POP: begin
                    if (r_head == r_tail) begin
                        r_in_frz <= 1'b0;
                        r_y      <= r_scan;
                        r_state  <= ST_G_RD;
                    end else begin
                        r_state <= ST_F_POPW;
                    end
                end
                ST_F_POPW: begin
                    r_v     <= qu_q;
                    r_head  <= r_head + 1'b1;
                    r_s     <= '0;
                    r_state <= ST_F_CH;
                end
                ST_F_CH: r_state <= ST_F_CHW;
                ST_F_CHW: begin
                    if (ch_q[NB]) begin
                        r_s     <= r_s + 1'b1;
                        r_state <= (r_s == SYM_LAST) ? ST_F_POP : ST_F_CH;
                    end else begin
                        r_ch <= ch_q[NB-1:0];
                        if (r_v == '0) begin
                            r_lk    <= '0;
                            r_state <= ST_F_LINK;
                        end else begin
                            r_y      <= sf_q;
                            r_in_frz <= 1'b1;
                            r_state  <= ST_G_RD;
                        end
                    end
                end
                ST_F_LINK: r_state <= ST_F_LINKW;
                ST_F_LINKW: begin
                    if (r_tail < NODES_END) r_tail <= r_tail + 1'b1;
                    r_s     <= r_s + 1'b1;
                    r_state <= (r_s == SYM_LAST) ? ST_F_POP : ST_F_CH;
                end
                // goto walk along suffix links
                ST_G_RD: r_state <= ST_G_EV;
                ST_G_EV: begin
                    if (ch_q[NB] && r_y != '0) begin
                        r_y     <= sf_q;
                        r_state <= ST_G_RD;
                    end else if (r_in_frz) begin
                        r_lk    <= ch_q[NB] ? '0 : ch_q[NB-1:0];
                        r_state <= ST_F_LINK;
                    end else begin
                        r_scan  <= ch_q[NB] ? '0 : ch_q[NB-1:0];
                        r_state <= ST_S_EXT;
                    end
                end
                ST_S_EXT: r_state <= ST_S_EXTW;
                ST_S_EXTW: begin
                    r_res_node <= NODE_W'(r_scan);
                    if (ex_q[NB]) begin
                        r_state <= ST_RESP;
                    end else begin
                        r_res_found <= 1'b1;
                        r_res_mnode <= NODE_W'(ex_q[NB-1:0]);
                        r_wa        <= ex_q[NB-1:0];
                        r_state     <= ST_CNT_RD;
                    end
                end
                // hand the result to the output register
                ST_RESP: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_node   <= r_res_node;
                        r_o_found  <= r_res_found;
                        r_o_mnode  <= r_res_mnode;
                        r_o_count  <= r_res_count;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.status      = r_o_status;
    assign o_out.node        = r_o_node;
    assign o_out.match_found = r_o_found;
    assign o_out.match_node  = r_o_mnode;
    assign o_out.word_count  = r_o_count;

    mpam_ram #(.WIDTH(NB+1), .DEPTH(MAX_NODES*ALPHABET_SIZE)) u_child (
        .i_clk, .i_we(ch_we), .i_waddr(ch_addr), .i_wdata(ch_wd),
        .i_raddr(ch_addr), .o_rdata(ch_q));
    mpam_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_words (
        .i_clk, .i_we(wd_we), .i_waddr(wd_wa), .i_wdata(wd_wd),
        .i_raddr(wd_ra), .o_rdata(wd_q));
    mpam_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_suffix (
        .i_clk, .i_we(sf_we), .i_waddr(sf_wa), .i_wdata(sf_wd),
        .i_raddr(sf_ra), .o_rdata(sf_q));
    mpam_ram #(.WIDTH(NB+1), .DEPTH(MAX_NODES)) u_exit (
        .i_clk, .i_we(ex_we), .i_waddr(ex_wa), .i_wdata(ex_wd),
        .i_raddr(ex_ra), .o_rdata(ex_q));
    mpam_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_queue (
        .i_clk, .i_we(qu_we), .i_waddr(qu_wa), .i_wdata(qu_wd),
        .i_raddr(qu_ra), .o_rdata(qu_q));

endmodule
